FILE: src/rast_pkg.sv
// ---------------------------------------------------------------------------
// rast_pkg: shared types, codes and microcode for the RARP address server
// Control word layout, step and condition codes, status codes and the
// microprogram held as a read-only table.
// ---------------------------------------------------------------------------
`default_nettype none

package rast_pkg;

	localparam int MAC_W            = 48;
	localparam int IP_W             = 32;
	localparam int HB_W             = 8;
	localparam int PFX_W            = IP_W - HB_W;
	localparam int STATUS_W         = 3;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = MAC_W;
	localparam int CFG_NUM          = 3;
	localparam int TABLE_DEPTH_DEF  = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MY_MAC        = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MY_IP         = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_ENABLE = CFG_IDX_W'(CFG_NUM - 1);

	typedef enum logic [STATUS_W-1:0] {
		STAT_SENT    = 3'd0,
		STAT_LEARNED = 3'd1,
		STAT_IGNORED = 3'd2,
		STAT_OFF     = 3'd3,
		STAT_FULL    = 3'd4,
		STAT_NOFREE  = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_REPLY,
		S_LEARN,
		S_IGN,
		S_REQ,
		S_OFF,
		S_SRCH_CHK,
		S_SRCH_CMP,
		S_HIT,
		S_NEW,
		S_FULL,
		S_SCAN_CHK,
		S_SCAN_CMP,
		S_BUMP,
		S_NOFREE,
		S_WRITE
	} step_t;

	typedef enum logic [3:0] {
		C_NO_IN,
		C_IS_REQ,
		C_NOT_MINE,
		C_SRV_OFF,
		C_OUT_BUSY,
		C_K_END,
		C_MAC_HIT,
		C_FULL,
		C_IP_HIT,
		C_WRAP
	} cond_t;

	// one table entry: client MAC, network prefix and host byte
	typedef struct packed {
		logic [MAC_W-1:0] mac;
		logic [PFX_W-1:0] prefix;
		logic [HB_W-1:0]  hb;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// microcode word; actions fire only when the jump is not taken
	typedef struct packed {
		cond_t   cond;
		step_t   jmp;
		step_t   nxt;
		logic    accept;
		logic    clr_k;
		logic    inc_k;
		logic    init_hb;
		logic    step_hb;
		logic    wr_entry;
		logic    learn;
		logic    load_out;
		logic    src_ram;
		status_t status;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		logic    idle;
		logic    accept;
		logic    clr_k;
		logic    inc_k;
		logic    init_hb;
		logic    step_hb;
		logic    wr_entry;
		logic    learn;
		logic    load_out;
		logic    src_ram;
		status_t status;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic no_in;
		logic is_req;
		logic not_mine;
		logic srv_off;
		logic out_busy;
		logic k_end;
		logic mac_hit;
		logic full;
		logic ip_hit;
		logic wrap;
	} flags_t;

	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		w = '0;
		w.cond = C_OUT_BUSY;
		w.jmp  = s;
		w.nxt  = S_IDLE;
		unique case (s)
			S_IDLE: begin
				w.cond = C_NO_IN;   w.jmp = S_IDLE;     w.nxt = S_DISP;
				w.accept = 1'b1;    w.clr_k = 1'b1;
			end
			S_DISP: begin
				w.cond = C_IS_REQ;  w.jmp = S_REQ;      w.nxt = S_REPLY;
			end
			S_REPLY: begin
				w.cond = C_NOT_MINE; w.jmp = S_IGN;     w.nxt = S_LEARN;
			end
			S_LEARN: begin
				w.load_out = 1'b1;  w.learn = 1'b1;     w.status = STAT_LEARNED;
			end
			S_IGN: begin
				w.load_out = 1'b1;  w.status = STAT_IGNORED;
			end
			S_REQ: begin
				w.cond = C_SRV_OFF; w.jmp = S_OFF;      w.nxt = S_SRCH_CHK;
			end
			S_OFF: begin
				w.load_out = 1'b1;  w.status = STAT_OFF;
			end
			S_SRCH_CHK: begin
				w.cond = C_K_END;   w.jmp = S_NEW;      w.nxt = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				w.cond = C_MAC_HIT; w.jmp = S_HIT;      w.nxt = S_SRCH_CHK;
				w.inc_k = 1'b1;
			end
			S_HIT: begin
				w.load_out = 1'b1;  w.src_ram = 1'b1;   w.status = STAT_SENT;
			end
			S_NEW: begin
				w.cond = C_FULL;    w.jmp = S_FULL;     w.nxt = S_SCAN_CHK;
				w.init_hb = 1'b1;   w.clr_k = 1'b1;
			end
			S_FULL: begin
				w.load_out = 1'b1;  w.status = STAT_FULL;
			end
			S_SCAN_CHK: begin
				w.cond = C_K_END;   w.jmp = S_WRITE;    w.nxt = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				w.cond = C_IP_HIT;  w.jmp = S_BUMP;     w.nxt = S_SCAN_CHK;
				w.inc_k = 1'b1;
			end
			S_BUMP: begin
				w.cond = C_WRAP;    w.jmp = S_NOFREE;   w.nxt = S_SCAN_CHK;
				w.step_hb = 1'b1;   w.clr_k = 1'b1;
			end
			S_NOFREE: begin
				w.load_out = 1'b1;  w.status = STAT_NOFREE;
			end
			S_WRITE: begin
				w.load_out = 1'b1;  w.wr_entry = 1'b1;  w.status = STAT_SENT;
			end
			default: begin
				w.cond = C_NO_IN;   w.jmp = S_IDLE;     w.nxt = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: src/rast_if.sv
// ---------------------------------------------------------------------------
// rast_if: channel interfaces of the RARP address server
// Packet input, result output and configuration write channels, each with
// valid/ready and a source and a sink modport.
// ---------------------------------------------------------------------------
`default_nettype none

interface rast_pkt_if import rast_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             is_reply;
	logic [MAC_W-1:0] sender_mac;
	logic [MAC_W-1:0] target_mac;
	logic [IP_W-1:0]  target_ip;

	modport source (output valid, is_reply, sender_mac, target_mac, target_ip,
		input ready);
	modport sink (input valid, is_reply, sender_mac, target_mac, target_ip,
		output ready);
endinterface

interface rast_res_if import rast_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [MAC_W-1:0]    dest_mac;
	logic [IP_W-1:0]     assigned_ip;
	logic [IP_W-1:0]     learned_ip;

	modport source (output valid, status, dest_mac, assigned_ip, learned_ip,
		input ready);
	modport sink (input valid, status, dest_mac, assigned_ip, learned_ip,
		output ready);
endinterface

interface rast_cfg_if import rast_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/rast_ram.sv
// ---------------------------------------------------------------------------
// rast_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ---------------------------------------------------------------------------
`default_nettype none

module rast_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire             clk,
	input  wire             we,
	input  wire [AW-1:0]    waddr,
	input  wire [WIDTH-1:0] wdata,
	input  wire [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: src/rast_seq.sv
// ---------------------------------------------------------------------------
// rast_seq: microcode sequencer
// Step counter, control store lookup and condition-driven next step.
// ---------------------------------------------------------------------------
`default_nettype none

module rast_seq import rast_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire flags_t flags,
	output ctrl_t       ctrl
);

	step_t  step_q, step_d;
	ucode_t word;
	logic   taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		word = ucode_rom(step_q);
		unique case (word.cond)
			C_NO_IN:    taken = flags.no_in;
			C_IS_REQ:   taken = flags.is_req;
			C_NOT_MINE: taken = flags.not_mine;
			C_SRV_OFF:  taken = flags.srv_off;
			C_OUT_BUSY: taken = flags.out_busy;
			C_K_END:    taken = flags.k_end;
			C_MAC_HIT:  taken = flags.mac_hit;
			C_FULL:     taken = flags.full;
			C_IP_HIT:   taken = flags.ip_hit;
			C_WRAP:     taken = flags.wrap;
			default:    taken = 1'b0;
		endcase
		step_d = taken ? word.jmp : word.nxt;

		// actions belong to the fall-through path
		ctrl.idle     = (step_q == S_IDLE);
		ctrl.accept   = word.accept   & ~taken;
		ctrl.clr_k    = word.clr_k    & ~taken;
		ctrl.inc_k    = word.inc_k    & ~taken;
		ctrl.init_hb  = word.init_hb  & ~taken;
		ctrl.step_hb  = word.step_hb  & ~taken;
		ctrl.wr_entry = word.wr_entry & ~taken;
		ctrl.learn    = word.learn    & ~taken;
		ctrl.load_out = word.load_out & ~taken;
		ctrl.src_ram  = word.src_ram;
		ctrl.status   = word.status;
	end

`ifndef NO_ASSERTIONS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept |-> step_q == S_IDLE)
		else $error("packet taken outside idle step");
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept |=> step_q == S_DISP)
		else $error("sequencer did not start after a packet");
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |=> step_q == S_IDLE)
		else $error("sequencer did not return to idle after a result");
`endif

endmodule

`default_nettype wire

FILE: src/rast_dp.sv
// ---------------------------------------------------------------------------
// rast_dp: datapath of the RARP address server
// Config registers, packet latch, table RAM, scan counter, host-byte
// generator, condition flags and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rast_dp import rast_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire ctrl_t     ctrl,
	output flags_t         flags,
	rast_pkt_if.sink       pkt,
	rast_res_if.source     res,
	rast_cfg_if.sink       cfg
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// configuration
	logic [MAC_W-1:0] my_mac_q;
	logic [IP_W-1:0]  my_ip_q;
	logic             srv_en_q;

	// latched packet
	logic             is_reply_q;
	logic [MAC_W-1:0] sender_q;
	logic [MAC_W-1:0] target_mac_q;
	logic [IP_W-1:0]  target_ip_q;

	// table control and new-entry candidate
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] k_q;
	logic [HB_W-1:0]  hb_q, first_q, step_q;
	logic [PFX_W-1:0] prefix_q;
	logic [HB_W-1:0]  step_new;
	logic [HB_W-1:0]  hb_next;

	// result register
	logic                res_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [MAC_W-1:0]    dest_q;
	logic [IP_W-1:0]     assigned_q;
	logic [IP_W-1:0]     learned_q;

	entry_t rd_entry, wr_entry;
	logic   out_busy;

	assign cfg.ready = 1'b1;
	assign pkt.ready = ctrl.idle;

	assign step_new = HB_W'(count_q) + HB_W'(1);
	assign hb_next  = hb_q + step_q;
	assign out_busy = res_valid_q & ~res.ready;

	assign wr_entry.mac    = sender_q;
	assign wr_entry.prefix = prefix_q;
	assign wr_entry.hb     = hb_q;

	rast_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ctrl.wr_entry),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_entry),
		.raddr (k_q[AW-1:0]),
		.rdata (rd_entry)
	);

	always_comb begin
		flags.no_in    = ~pkt.valid;
		flags.is_req   = ~is_reply_q;
		flags.not_mine = (target_mac_q != my_mac_q);
		flags.srv_off  = ~srv_en_q;
		flags.out_busy = out_busy;
		flags.k_end    = (k_q == count_q);
		flags.mac_hit  = (rd_entry.mac == sender_q);
		flags.full     = (count_q == CNT_W'(TABLE_DEPTH));
		flags.ip_hit   = (rd_entry.prefix == prefix_q) && (rd_entry.hb == hb_q);
		flags.wrap     = (hb_next == first_q);
	end

	// config registers; a learned address overwrites my_ip
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_mac_q <= '0;
			my_ip_q  <= '0;
			srv_en_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MY_MAC:        my_mac_q <= cfg.data;
				REG_MY_IP:         my_ip_q  <= cfg.data[IP_W-1:0];
				REG_SERVER_ENABLE: srv_en_q <= cfg.data[0];
				default:           ;
			endcase
		end else if (ctrl.learn) begin
			my_ip_q <= target_ip_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			is_reply_q   <= pkt.is_reply;
			sender_q     <= pkt.sender_mac;
			target_mac_q <= pkt.target_mac;
			target_ip_q  <= pkt.target_ip;
		end
		if (ctrl.init_hb) begin
			step_q   <= step_new;
			hb_q     <= my_ip_q[HB_W-1:0] + step_new;
			first_q  <= my_ip_q[HB_W-1:0] + step_new;
			prefix_q <= my_ip_q[IP_W-1:HB_W];
		end else if (ctrl.step_hb) begin
			hb_q <= hb_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
		end else begin
			if (ctrl.wr_entry) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctrl.clr_k) begin
				k_q <= '0;
			end else if (ctrl.inc_k) begin
				k_q <= k_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			status_q   <= ctrl.status;
			dest_q     <= (ctrl.status == STAT_SENT) ? sender_q : '0;
			learned_q  <= (ctrl.status == STAT_LEARNED) ? target_ip_q : '0;
			if (ctrl.status != STAT_SENT) begin
				assigned_q <= '0;
			end else if (ctrl.src_ram) begin
				assigned_q <= {rd_entry.prefix, rd_entry.hb};
			end else begin
				assigned_q <= {prefix_q, hb_q};
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = status_q;
	assign res.dest_mac    = dest_q;
	assign res.assigned_ip = assigned_q;
	assign res.learned_ip  = learned_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_entry |-> count_q < CNT_W'(TABLE_DEPTH))
		else $error("table write with no free slot");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_entry |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("entry count did not advance on a new entry");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> !out_busy)
		else $error("result loaded over an unread result");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= count_q)
		else $error("scan index ran past the valid entries");
`endif

endmodule

`default_nettype wire

FILE: src/rarp_address_server_table_top.sv
// Steps: a reply goes through dispatch and the owner check to its result step;
// a request costs a check and a compare step per entry searched; a new client
// adds a check and a compare step per older entry per host-byte candidate.
// Throughput: one packet at a time through the microcode sequencer; the next
// packet is taken as soon as the result is in the output register.
// Reset: sequencer to idle, config and entry count to zero; table RAM
// contents are left undefined and need no clearing pass.
// ---------------------------------------------------------------------------
// rarp_address_server_table_top: RARP address server with client table
// Microcoded sequencer over a datapath holding the client table RAM.
// ---------------------------------------------------------------------------
`default_nettype none

module rarp_address_server_table_top import rast_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input wire         clk,
	input wire         arst_n,
	rast_pkt_if.sink   pkt,
	rast_res_if.source res,
	rast_cfg_if.sink   cfg
);

	// Control path: the sequencer steps through a short microprogram. Each
	// control word tests one datapath flag, jumps on it, and otherwise fires
	// its actions and moves to its fall-through step.
	ctrl_t  ctrl;
	flags_t flags;

	rast_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// Datapath: packet latch, config registers, table RAM with a single scan
	// index (registered read, so each table entry costs a check and a
	// compare step), host-byte candidate and the result register that
	// decouples the two channels.
	rast_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.flags  (flags),
		.pkt    (pkt),
		.res    (res),
		.cfg    (cfg)
	);

endmodule

`default_nettype wire
